>>> src/lzwvwd_pkg.sv
package lzwvwd_pkg;

  localparam int unsigned DICT_ENTRIES  = 4096;
  localparam int unsigned MAX_CODE_BITS = 12;
  localparam int unsigned MAX_STRING    = 512;

  localparam int unsigned CODE_W = MAX_CODE_BITS;
  localparam int unsigned DICT_W = $clog2(DICT_ENTRIES);
  localparam int unsigned NE_W   = DICT_W + 1;
  localparam int unsigned STK_W  = $clog2(MAX_STRING);
  localparam int unsigned LEN_W  = STK_W + 1;

  localparam logic [CODE_W-1:0] CODE_CLEAR = CODE_W'(256);
  localparam logic [CODE_W-1:0] CODE_GROW  = CODE_W'(257);
  localparam logic [CODE_W-1:0] CODE_END   = CODE_W'(258);
  localparam logic [NE_W-1:0]   FIRST_FREE = NE_W'(259);
  localparam logic [4:0]        START_WIDTH = 5'd9;
  localparam logic [4:0]        MAX_WIDTH   = 5'(MAX_CODE_BITS);
  localparam logic [CODE_W-1:0] LIT_MAX    = CODE_W'(8'hFF);
  localparam logic [NE_W-1:0]   DICT_LIMIT = NE_W'(DICT_ENTRIES);
  localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(MAX_STRING);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERRUN  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_WIDTH    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [2:0] REG_TOTAL_SIZE = 3'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WALK_DATA,
    S_CHECK,
    S_POP,
    S_POP_DATA,
    S_EMIT
  } state_e;

endpackage

>>> src/lzw_variable_width_decoder_top.sv
// a byte that ends no code goes from idle to emit, a literal or control code via decode,
// else decode, chain walk (walk, walk_data), check, then pop and pop_data per output byte
// throughput: one input byte per request, not ready again until the last result is registered
// the chain walk fills the stack through its one write port, the output unpacking reads it back
// reset: asynchronous active low, dictionary and stack contents stay undefined
module lzw_variable_width_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_count_o,
  output logic        out_last_o,
  output logic [2:0]  status_o,
  output logic        finished_o
);

  localparam int unsigned CW = lzwvwd_pkg::CODE_W;
  localparam int unsigned DW = lzwvwd_pkg::DICT_W;
  localparam int unsigned NW = lzwvwd_pkg::NE_W;
  localparam int unsigned SW = lzwvwd_pkg::STK_W;
  localparam int unsigned LW = lzwvwd_pkg::LEN_W;

  lzwvwd_pkg::state_e state_q, state_d;

  logic [31:0]   total_q;
  logic [23:0]   buf_q, buf_d;
  logic [4:0]    bcnt_q, bcnt_d;
  logic [4:0]    width_q, width_d;
  logic [NW-1:0] next_q, next_d;
  logic [CW-1:0] prev_q, prev_d;
  logic [7:0]    pfirst_q, pfirst_d;
  logic          await_q, await_d;
  logic [31:0]   prod_q, prod_d;
  logic [2:0]    err_q, err_d;
  logic [CW-1:0] code_q, code_d;
  logic [CW-1:0] c_q, c_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [63:0]   data_q, data_d;
  logic [3:0]    cnt_q, cnt_d;

  logic          ov_q, ov_d;
  logic [63:0]   od_q, od_d;
  logic [3:0]    oc_q, oc_d;
  logic          ol_q, ol_d;
  logic [2:0]    os_q, os_d;
  logic          of_q, of_d;

  logic [CW-1:0] dict_prefix [lzwvwd_pkg::DICT_ENTRIES];
  logic [7:0]    dict_suffix [lzwvwd_pkg::DICT_ENTRIES];
  logic [7:0]    stack_mem   [lzwvwd_pkg::MAX_STRING];
  logic [CW-1:0] pre_rd_q;
  logic [7:0]    suf_rd_q;
  logic [7:0]    stk_rd_q;

  logic          dict_we;
  logic [DW-1:0] dict_wa;
  logic          stk_we;
  logic [SW-1:0] stk_wa;
  logic [7:0]    stk_wd;
  logic [SW-1:0] stk_ra;

  logic          cfg_we;
  logic [23:0]   nbuf;
  logic [4:0]    nbcnt;
  logic [4:0]    shamt;
  logic [23:0]   shifted;
  logic [15:0]   wmask;
  logic [32:0]   need;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == lzwvwd_pkg::REG_TOTAL_SIZE);
  assign prdata = (paddr == lzwvwd_pkg::REG_TOTAL_SIZE) ? total_q : 32'd0;

  assign in_stall_o  = (state_q != lzwvwd_pkg::S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_count_o = oc_q;
  assign out_last_o  = ol_q;
  assign status_o    = os_q;
  assign finished_o  = of_q;

  assign dict_wa = next_q[DW-1:0];
  assign stk_ra  = SW'(rem_q - LW'(1));
  assign nbuf    = {buf_q[15:0], in_byte_i};
  assign nbcnt   = bcnt_q + 5'd8;
  assign shamt   = nbcnt - width_q;
  assign shifted = nbuf >> shamt;
  assign wmask   = 16'((17'd1 << width_q) - 17'd1);
  assign need    = {1'b0, prod_q} + 33'(len_q);

  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_prefix[dict_wa] <= prev_q;
      dict_suffix[dict_wa] <= c_q[7:0];
    end
    pre_rd_q <= dict_prefix[c_q[DW-1:0]];
    suf_rd_q <= dict_suffix[c_q[DW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stack_mem[stk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lzwvwd_pkg::S_IDLE;
      total_q  <= 32'd0;
      buf_q    <= 24'd0;
      bcnt_q   <= 5'd0;
      width_q  <= lzwvwd_pkg::START_WIDTH;
      next_q   <= lzwvwd_pkg::FIRST_FREE;
      prev_q   <= '0;
      pfirst_q <= 8'd0;
      await_q  <= 1'b1;
      prod_q   <= 32'd0;
      err_q    <= lzwvwd_pkg::ST_OK;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we) begin
        total_q <= pwdata;
      end
      buf_q    <= buf_d;
      bcnt_q   <= bcnt_d;
      width_q  <= width_d;
      next_q   <= next_d;
      prev_q   <= prev_d;
      pfirst_q <= pfirst_d;
      await_q  <= await_d;
      prod_q   <= prod_d;
      err_q    <= err_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    c_q    <= c_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    data_q <= data_d;
    cnt_q  <= cnt_d;
    od_q   <= od_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    os_q   <= os_d;
    of_q   <= of_d;
  end

  always_comb begin
    state_d  = state_q;
    buf_d    = buf_q;
    bcnt_d   = bcnt_q;
    width_d  = width_q;
    next_d   = next_q;
    prev_d   = prev_q;
    pfirst_d = pfirst_q;
    await_d  = await_q;
    prod_d   = prod_q;
    err_d    = err_q;
    code_d   = code_q;
    c_d      = c_q;
    len_d    = len_q;
    rem_d    = rem_q;
    data_d   = data_q;
    cnt_d    = cnt_q;
    ov_d     = ov_q && out_stall_i;
    od_d     = od_q;
    oc_d     = oc_q;
    ol_d     = ol_q;
    os_d     = os_q;
    of_d     = of_q;
    dict_we  = 1'b0;
    stk_we   = 1'b0;
    stk_wa   = len_q[SW-1:0];
    stk_wd   = 8'd0;

    case (state_q)
      lzwvwd_pkg::S_IDLE: begin
        data_d = 64'd0;
        cnt_d  = 4'd0;
        rem_d  = '0;
        if (in_valid_i) begin
          state_d = lzwvwd_pkg::S_EMIT;
          if (err_q == lzwvwd_pkg::ST_OK && prod_q < total_q) begin
            buf_d  = nbuf;
            bcnt_d = nbcnt;
            if (nbcnt >= width_q) begin
              bcnt_d  = shamt;
              code_d  = CW'(shifted & {8'd0, wmask});
              state_d = lzwvwd_pkg::S_DECODE;
            end
          end
        end
      end
      lzwvwd_pkg::S_DECODE: begin
        state_d = lzwvwd_pkg::S_EMIT;
        if (await_q) begin
          if (code_q == lzwvwd_pkg::CODE_CLEAR || code_q == lzwvwd_pkg::CODE_END) begin
          end else if (code_q > lzwvwd_pkg::LIT_MAX) begin
            err_d = lzwvwd_pkg::ST_UNKNOWN;
          end else begin
            data_d   = {code_q[7:0], 56'd0};
            cnt_d    = 4'd1;
            prod_d   = prod_q + 32'd1;
            prev_d   = code_q;
            pfirst_d = code_q[7:0];
            await_d  = 1'b0;
          end
        end else if (code_q == lzwvwd_pkg::CODE_CLEAR || code_q == lzwvwd_pkg::CODE_END) begin
          width_d = lzwvwd_pkg::START_WIDTH;
          next_d  = lzwvwd_pkg::FIRST_FREE;
          await_d = 1'b1;
        end else if (code_q == lzwvwd_pkg::CODE_GROW) begin
          if (width_q >= lzwvwd_pkg::MAX_WIDTH) begin
            err_d = lzwvwd_pkg::ST_WIDTH;
          end else begin
            width_d = width_q + 5'd1;
          end
        end else if (NW'(code_q) > next_q || NW'(code_q) >= lzwvwd_pkg::DICT_LIMIT) begin
          err_d = lzwvwd_pkg::ST_UNKNOWN;
        end else begin
          state_d = lzwvwd_pkg::S_WALK;
          if (NW'(code_q) == next_q) begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = pfirst_q;
            len_d  = LW'(1);
            c_d    = prev_q;
          end else begin
            len_d  = '0;
            c_d    = code_q;
          end
        end
      end
      lzwvwd_pkg::S_WALK: begin
        if (len_q >= lzwvwd_pkg::LEN_LIMIT) begin
          err_d   = lzwvwd_pkg::ST_TOO_LONG;
          state_d = lzwvwd_pkg::S_EMIT;
        end else if (c_q <= lzwvwd_pkg::LIT_MAX) begin
          stk_we  = 1'b1;
          stk_wd  = c_q[7:0];
          len_d   = len_q + LW'(1);
          state_d = lzwvwd_pkg::S_CHECK;
        end else if (NW'(c_q) >= lzwvwd_pkg::DICT_LIMIT) begin
          stk_we = 1'b1;
          stk_wd = 8'd0;
          len_d  = len_q + LW'(1);
          c_d    = '0;
        end else begin
          state_d = lzwvwd_pkg::S_WALK_DATA;
        end
      end
      lzwvwd_pkg::S_WALK_DATA: begin
        stk_we  = 1'b1;
        stk_wd  = suf_rd_q;
        len_d   = len_q + LW'(1);
        c_d     = pre_rd_q;
        state_d = lzwvwd_pkg::S_WALK;
      end
      lzwvwd_pkg::S_CHECK: begin
        if (need > {1'b0, total_q}) begin
          err_d   = lzwvwd_pkg::ST_OVERRUN;
          state_d = lzwvwd_pkg::S_EMIT;
        end else begin
          if (next_q < lzwvwd_pkg::DICT_LIMIT) begin
            dict_we = 1'b1;
            next_d  = next_q + NW'(1);
          end
          prod_d   = need[31:0];
          prev_d   = code_q;
          pfirst_d = c_q[7:0];
          rem_d    = len_q;
          state_d  = lzwvwd_pkg::S_POP;
        end
      end
      lzwvwd_pkg::S_POP: begin
        if (rem_q == '0 || cnt_q == 4'd8) begin
          state_d = lzwvwd_pkg::S_EMIT;
        end else begin
          rem_d   = rem_q - LW'(1);
          state_d = lzwvwd_pkg::S_POP_DATA;
        end
      end
      lzwvwd_pkg::S_POP_DATA: begin
        data_d  = data_q | ({56'd0, stk_rd_q} << (6'd8 * (6'd7 - {3'd0, cnt_q[2:0]})));
        cnt_d   = cnt_q + 4'd1;
        state_d = lzwvwd_pkg::S_POP;
      end
      lzwvwd_pkg::S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d   = 1'b1;
          od_d   = data_q;
          oc_d   = cnt_q;
          ol_d   = (rem_q == '0);
          os_d   = err_q;
          of_d   = (prod_q >= total_q);
          data_d = 64'd0;
          cnt_d  = 4'd0;
          state_d = (rem_q == '0) ? lzwvwd_pkg::S_IDLE : lzwvwd_pkg::S_POP;
        end
      end
      default: begin
        state_d = lzwvwd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> src/lzwvwd_checker.sv
module lzwvwd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_data_o,
  input logic [3:0]  out_count_o
);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_count_o <= 4'd8)
    else $error("result count above eight");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_count_o == 4'd0) |-> out_data_o == 64'd0)
    else $error("empty result carries data");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a request is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind lzw_variable_width_decoder_top lzwvwd_checker u_lzwvwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .out_count_o (out_count_o)
);
